FILE: sv/sorted_deque_table_macros.svh
// ---------------------------------------------------------------------------
// sorted_deque_table_macros: assertion macros for the sorted deque table
// Clocked assertion wrappers; ASSERT_OFF compiles them away.
// ---------------------------------------------------------------------------
`ifndef SORTED_DEQUE_TABLE_MACROS_SVH
`define SORTED_DEQUE_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define SDT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every rising clock edge, reset included
`define SDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SDT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/sdt_pkg.sv
// ---------------------------------------------------------------------------
// sdt_pkg: shared types and constants of the sorted deque table
// Sizes, action and status codes, and the control word sent to each cell.
// ---------------------------------------------------------------------------
`default_nettype none

package sdt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int PAY_W    = 64;
	localparam int ACT_W    = 3;
	localparam int ST_W     = 2;
	localparam int OCC_W    = 5;

	// requested action
	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_BACK  = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_SORTED     = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_POP_FRONT  = 3'd4,
		ACT_REMOVE     = 3'd5,
		ACT_DUMP_FWD   = 3'd6,
		ACT_DUMP_BWD   = 3'd7
	} act_t;

	// result status
	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// cell update: keep, open a gap at pos, or close the gap at pos
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2
	} cell_op_t;

	// control word broadcast along the row of cells
	typedef struct packed {
		cell_op_t                 op;
		logic [IDX_W-1:0]         pos;
		logic signed [KEY_W-1:0]  key;
		logic [PAY_W-1:0]         payload;
		logic                     cmp_gt;
	} cell_ctl_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_CMP  = 2'd1,
		S_SCAN = 2'd2,
		S_DUMP = 2'd3
	} fsm_t;

endpackage

`default_nettype wire

FILE: sv/sorted_deque_table.sv
// ---------------------------------------------------------------------------
// sorted_deque_table: bounded ordered list of key/payload records
// Row of slot cells with a sequencer for insert, pop, remove and dump.
// ---------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low; action, key and payload are sampled there. Results come back on
//   status, out_key, out_payload, last and occupancy, each valid for exactly
//   one cycle while strobe is high; the receiver cannot stall them.
//   Every action gives one result with last set, except a dump of a
//   non-empty list, which gives one result per record, last on the final one.
//   Push and pop, and refused or empty cases, give their result from the
//   compare state, through the result registers.
//   After the compare state, sorted insert and remove by key scan the slots
//   one per cycle, stopping at the first hit or past the last record held.
//   A dump gives its results on consecutive cycles.
//   busy stays high until the final result is registered; a new command can
//   be taken in the cycle that the final result is shown.
//   Reset (arst_n low) empties the list; slot contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_deque_table_macros.svh"

module sorted_deque_table (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [sdt_pkg::ACT_W-1:0]         action,
	input  wire logic signed [sdt_pkg::KEY_W-1:0]  key,
	input  wire logic [sdt_pkg::PAY_W-1:0]         payload,
	output logic                                   busy,
	output logic                                   strobe,
	output logic [sdt_pkg::ST_W-1:0]               status,
	output logic signed [sdt_pkg::KEY_W-1:0]       out_key,
	output logic [sdt_pkg::PAY_W-1:0]              out_payload,
	output logic                                   last,
	output logic [sdt_pkg::OCC_W-1:0]              occupancy
);

	// control state
	sdt_pkg::fsm_t                   state_q, state_d;
	logic [sdt_pkg::CNT_W-1:0]       count_q, count_d;
	logic [sdt_pkg::CNT_W-1:0]       ptr_q, ptr_d;
	logic                            strobe_q;

	// command and search registers
	sdt_pkg::act_t                   act_q;
	logic signed [sdt_pkg::KEY_W-1:0] key_q;
	logic [sdt_pkg::PAY_W-1:0]       pay_q;
	logic [sdt_pkg::CAPACITY-1:0]    hit_q;

	// result registers
	sdt_pkg::status_t                status_q, st_d;
	logic signed [sdt_pkg::KEY_W-1:0] okey_q, okey_d;
	logic [sdt_pkg::PAY_W-1:0]       opay_q, opay_d;
	logic                            last_q, last_d;
	logic [sdt_pkg::OCC_W-1:0]       occ_q;
	logic                            emit;

	// cell row
	sdt_pkg::cell_ctl_t              ctl;
	logic signed [sdt_pkg::KEY_W-1:0] cell_key [sdt_pkg::CAPACITY];
	logic [sdt_pkg::PAY_W-1:0]       cell_pay [sdt_pkg::CAPACITY];
	logic [sdt_pkg::CAPACITY-1:0]    cell_hit;
	logic [sdt_pkg::CAPACITY-1:0]    occ_mask;

	// helpers
	logic                            full, empty, scan_end, ptr_hit, dump_end;
	logic [sdt_pkg::CNT_W-1:0]       cnt_m1;
	logic [sdt_pkg::IDX_W-1:0]       last_idx, ptr_idx, rd_idx;
	logic signed [sdt_pkg::KEY_W-1:0] rd_key;
	logic [sdt_pkg::PAY_W-1:0]       rd_pay;

	// row of slot cells, each wired to its neighbors
	for (genvar g = 0; g < sdt_pkg::CAPACITY; g++) begin : g_cell
		logic signed [sdt_pkg::KEY_W-1:0] lk, rk;
		logic [sdt_pkg::PAY_W-1:0]        lp, rp;

		if (g == 0) begin : g_first
			assign lk = '0;
			assign lp = '0;
		end else begin : g_left
			assign lk = cell_key[g-1];
			assign lp = cell_pay[g-1];
		end

		if (g == sdt_pkg::CAPACITY - 1) begin : g_final
			assign rk = '0;
			assign rp = '0;
		end else begin : g_right
			assign rk = cell_key[g+1];
			assign rp = cell_pay[g+1];
		end

		sdt_cell u_cell (
			.clk       (clk),
			.idx       (sdt_pkg::IDX_W'(g)),
			.ctl       (ctl),
			.left_key  (lk),
			.left_pay  (lp),
			.right_key (rk),
			.right_pay (rp),
			.cell_key  (cell_key[g]),
			.cell_pay  (cell_pay[g]),
			.hit       (cell_hit[g])
		);
	end

	// occupied slots
	always_comb begin
		for (int i = 0; i < sdt_pkg::CAPACITY; i++) begin
			occ_mask[i] = (sdt_pkg::CNT_W'(i) < count_q);
		end
	end

	// common flags
	assign full     = (count_q == sdt_pkg::CNT_W'(sdt_pkg::CAPACITY));
	assign empty    = (count_q == '0);
	assign cnt_m1   = count_q - sdt_pkg::CNT_W'(1);
	assign last_idx = cnt_m1[sdt_pkg::IDX_W-1:0];
	assign ptr_idx  = ptr_q[sdt_pkg::IDX_W-1:0];
	assign ptr_hit  = hit_q[ptr_idx];
	assign scan_end = (ptr_q == count_q) || ptr_hit;
	assign dump_end = (ptr_q == cnt_m1);
	assign rd_key   = cell_key[rd_idx];
	assign rd_pay   = cell_pay[rd_idx];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sdt_pkg::S_IDLE: begin
				if (start) state_d = sdt_pkg::S_CMP;
			end
			sdt_pkg::S_CMP: begin
				state_d = sdt_pkg::S_IDLE;
				case (act_q)
					sdt_pkg::ACT_SORTED: begin
						if (!full) state_d = sdt_pkg::S_SCAN;
					end
					sdt_pkg::ACT_REMOVE: begin
						if (!empty) state_d = sdt_pkg::S_SCAN;
					end
					sdt_pkg::ACT_DUMP_FWD, sdt_pkg::ACT_DUMP_BWD: begin
						if (!empty) state_d = sdt_pkg::S_DUMP;
					end
					default: begin
					end
				endcase
			end
			sdt_pkg::S_SCAN: begin
				if (scan_end) state_d = sdt_pkg::S_IDLE;
			end
			sdt_pkg::S_DUMP: begin
				if (dump_end) state_d = sdt_pkg::S_IDLE;
			end
			default: state_d = sdt_pkg::S_IDLE;
		endcase
	end

	// datapath control and result values
	always_comb begin
		ctl.op      = sdt_pkg::CELL_HOLD;
		ctl.pos     = '0;
		ctl.key     = key_q;
		ctl.payload = pay_q;
		ctl.cmp_gt  = (act_q == sdt_pkg::ACT_SORTED);
		count_d     = count_q;
		ptr_d       = ptr_q;
		rd_idx      = '0;
		emit        = 1'b0;
		st_d        = sdt_pkg::ST_OK;
		okey_d      = '0;
		opay_d      = '0;
		last_d      = 1'b1;
		case (state_q)
			sdt_pkg::S_CMP: begin
				ptr_d = '0;
				case (act_q)
					sdt_pkg::ACT_PUSH_BACK, sdt_pkg::ACT_PUSH_FRONT: begin
						emit = 1'b1;
						if (full) begin
							st_d = sdt_pkg::ST_FULL;
						end else begin
							ctl.op  = sdt_pkg::CELL_INS;
							ctl.pos = (act_q == sdt_pkg::ACT_PUSH_BACK) ?
								count_q[sdt_pkg::IDX_W-1:0] : '0;
							count_d = count_q + sdt_pkg::CNT_W'(1);
						end
					end
					sdt_pkg::ACT_SORTED: begin
						if (full) begin
							emit = 1'b1;
							st_d = sdt_pkg::ST_FULL;
						end
					end
					sdt_pkg::ACT_POP_BACK, sdt_pkg::ACT_POP_FRONT: begin
						emit = 1'b1;
						if (empty) begin
							st_d = sdt_pkg::ST_EMPTY;
						end else begin
							rd_idx  = (act_q == sdt_pkg::ACT_POP_BACK) ? last_idx : '0;
							okey_d  = rd_key;
							opay_d  = rd_pay;
							ctl.op  = sdt_pkg::CELL_DEL;
							ctl.pos = rd_idx;
							count_d = cnt_m1;
						end
					end
					default: begin
						// remove and dumps report an empty list right away
						if (empty) begin
							emit = 1'b1;
							st_d = sdt_pkg::ST_EMPTY;
						end
					end
				endcase
			end
			sdt_pkg::S_SCAN: begin
				if (ptr_q == count_q) begin
					// no stop found: sorted insert goes to the tail, remove reports not found
					emit = 1'b1;
					if (act_q == sdt_pkg::ACT_SORTED) begin
						ctl.op  = sdt_pkg::CELL_INS;
						ctl.pos = count_q[sdt_pkg::IDX_W-1:0];
						count_d = count_q + sdt_pkg::CNT_W'(1);
					end else begin
						st_d = sdt_pkg::ST_NOTFOUND;
					end
				end else if (ptr_hit) begin
					emit = 1'b1;
					if (act_q == sdt_pkg::ACT_SORTED) begin
						ctl.op  = sdt_pkg::CELL_INS;
						ctl.pos = ptr_idx;
						count_d = count_q + sdt_pkg::CNT_W'(1);
					end else begin
						rd_idx  = ptr_idx;
						okey_d  = rd_key;
						opay_d  = rd_pay;
						ctl.op  = sdt_pkg::CELL_DEL;
						ctl.pos = ptr_idx;
						count_d = cnt_m1;
					end
				end else begin
					ptr_d = ptr_q + sdt_pkg::CNT_W'(1);
				end
			end
			sdt_pkg::S_DUMP: begin
				emit   = 1'b1;
				rd_idx = (act_q == sdt_pkg::ACT_DUMP_FWD) ? ptr_idx : (last_idx - ptr_idx);
				okey_d = rd_key;
				opay_d = rd_pay;
				last_d = dump_end;
				ptr_d  = ptr_q + sdt_pkg::CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sdt_pkg::S_IDLE;
			count_q  <= '0;
			ptr_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			ptr_q    <= ptr_d;
			strobe_q <= emit;
		end
	end

	// command capture, hit vector and result registers
	always_ff @(posedge clk) begin
		if (state_q == sdt_pkg::S_IDLE && start) begin
			act_q <= sdt_pkg::act_t'(action);
			key_q <= key;
			pay_q <= payload;
		end
		if (state_q == sdt_pkg::S_CMP) begin
			hit_q <= cell_hit & occ_mask;
		end
		if (emit) begin
			status_q <= st_d;
			okey_q   <= okey_d;
			opay_q   <= opay_d;
			last_q   <= last_d;
			occ_q    <= sdt_pkg::OCC_W'(count_d);
		end
	end

	assign busy        = (state_q != sdt_pkg::S_IDLE);
	assign strobe      = strobe_q;
	assign status      = status_q;
	assign out_key     = okey_q;
	assign out_payload = opay_q;
	assign last        = last_q;
	assign occupancy   = occ_q;

	// checks
	`SDT_ASSERT(a_count_bound, clk, arst_n, count_q <= sdt_pkg::CNT_W'(sdt_pkg::CAPACITY), "record count above capacity")
	`SDT_ASSERT(a_strobe_busy, clk, arst_n, strobe_q |-> $past(busy), "result without a command in progress")
	`SDT_ASSERT(a_run_continues, clk, arst_n, (strobe_q && !last_q) |=> strobe_q, "dump run broken before last")
	`SDT_ASSERT(a_count_with_result, clk, arst_n, (count_q != $past(count_q)) |-> strobe_q, "record count changed without a result")
	`SDT_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> (state_q == sdt_pkg::S_IDLE && !strobe_q), "not idle in reset")

endmodule

`default_nettype wire

FILE: sv/sdt_cell.sv
// ---------------------------------------------------------------------------
// sdt_cell: one record slot of the sorted deque table
// Holds a key and payload, shifts with its neighbors and compares its key.
// ---------------------------------------------------------------------------
`default_nettype none

module sdt_cell (
	input  wire logic                              clk,
	input  wire logic [sdt_pkg::IDX_W-1:0]         idx,
	input  wire sdt_pkg::cell_ctl_t                ctl,
	input  wire logic signed [sdt_pkg::KEY_W-1:0]  left_key,
	input  wire logic [sdt_pkg::PAY_W-1:0]         left_pay,
	input  wire logic signed [sdt_pkg::KEY_W-1:0]  right_key,
	input  wire logic [sdt_pkg::PAY_W-1:0]         right_pay,
	output logic signed [sdt_pkg::KEY_W-1:0]       cell_key,
	output logic [sdt_pkg::PAY_W-1:0]              cell_pay,
	output logic                                   hit
);

	logic signed [sdt_pkg::KEY_W-1:0] key_q;
	logic [sdt_pkg::PAY_W-1:0]        pay_q;

	// slot update: insert opens a gap, delete pulls the right neighbor in
	always_ff @(posedge clk) begin
		case (ctl.op)
			sdt_pkg::CELL_INS: begin
				if (idx == ctl.pos) begin
					key_q <= ctl.key;
					pay_q <= ctl.payload;
				end else if (idx > ctl.pos) begin
					key_q <= left_key;
					pay_q <= left_pay;
				end
			end
			sdt_pkg::CELL_DEL: begin
				if (idx >= ctl.pos) begin
					key_q <= right_key;
					pay_q <= right_pay;
				end
			end
			default: begin
			end
		endcase
	end

	// local compare: strictly greater for sorted insert, equal for remove
	always_comb begin
		hit = ctl.cmp_gt ? (key_q > ctl.key) : (key_q == ctl.key);
	end

	assign cell_key = key_q;
	assign cell_pay = pay_q;

endmodule

`default_nettype wire
